/* src/sfc64_pkg.sv */
// Shared constants and helpers for the eight-lane SFC64 generator.
package sfc64_pkg;

   // Lane counts and word geometry.
   localparam int LANES_DEFAULT = 8;
   localparam int OUT_FIELDS    = 8;
   localparam int SEED_SLOTS    = 8;
   localparam int WORD_W        = 64;
   localparam int LANE_IDX_W    = 3;
   localparam int WORD_SEL_W    = 2;
   localparam int USER_W        = 1 + LANE_IDX_W + WORD_SEL_W;

   // SFC64 mixing constants.
   localparam int SHIFT_A = 11;
   localparam int SHIFT_B = 3;
   localparam int ROT_C   = 24;

   // Double conversion geometry.
   localparam int DROP_W   = 12;
   localparam int FRAC_W   = 52;
   localparam int EXP_W    = 11;
   localparam int POS_W    = 6;
   localparam int EXP_BASE = 971;

   // Request kinds.
   localparam logic FUNC_SEED = 1'b0;
   localparam logic FUNC_GEN  = 1'b1;

   // Seed word selectors.
   localparam logic [WORD_SEL_W-1:0] WORD_A   = 2'd0;
   localparam logic [WORD_SEL_W-1:0] WORD_B   = 2'd1;
   localparam logic [WORD_SEL_W-1:0] WORD_C   = 2'd2;
   localparam logic [WORD_SEL_W-1:0] WORD_CNT = 2'd3;

   // Output formats.
   localparam logic FMT_RAW    = 1'b0;
   localparam logic FMT_DOUBLE = 1'b1;

   // Position of the highest set bit of a mantissa; zero when none is set.
   function automatic logic [POS_W-1:0] lead_one(input logic [FRAC_W-1:0] m);
      logic [POS_W-1:0] p;
      p = '0;
      for (int k = 0; k < FRAC_W; k++) begin
         if (m[k]) begin
            p = POS_W'(k);
         end
      end
      return p;
   endfunction

endpackage

/* src/sfc64_eight_lane_generator_top.sv */
// Channel   Dir  Handshake              Payload
// req       in   req_tvalid/req_tready  tuser: func, lane_index, word_select; tdata: seed_value
// rsp       out  rsp_tvalid/rsp_tready  tdata: lane0_value .. lane7_value
// csr       in   csr_wr_en              csr_wr_data: output_format
//
// One beat is taken every cycle when the result side keeps up; a generate beat
// reaches rsp through three registers (sum, leading-one search, normalising
// shift), the first loaded at the edge that accepts it. Seed beats update
// state at acceptance and give no result.
// Reset clears all lane state, the format register and the pipeline valids.
// A stall on rsp fills the three stages and then drops req_tready.
module sfc64_eight_lane_generator_top
   import sfc64_pkg::*;
#(
   parameter int LANES = LANES_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   // Configuration
   input  logic                         csr_wr_en,
   input  logic                         csr_wr_data,   // output_format
   // Request channel
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [WORD_W-1:0]            req_tdata,     // seed_value
   input  logic [USER_W-1:0]            req_tuser,     // func, lane_index, word_select
   // Result channel
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [OUT_FIELDS*WORD_W-1:0] rsp_tdata      // lane0_value .. lane7_value
);

   // Request field split.
   logic                  req_func;
   logic [LANE_IDX_W-1:0] req_lane;
   logic [WORD_SEL_W-1:0] req_sel;

   assign req_func = req_tuser[0];
   assign req_lane = req_tuser[LANE_IDX_W:1];
   assign req_sel  = req_tuser[USER_W-1:LANE_IDX_W+1];

   // Pipeline handshakes.
   logic out_ready;
   logic s2_ready;
   logic s1_ready;
   logic req_fire;
   logic gen_fire;
   logic seed_fire;

   logic rsp_valid_ff, rsp_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s1_valid_ff, s1_valid_in;

   assign out_ready  = !rsp_valid_ff || rsp_tready;
   assign s2_ready   = !s2_valid_ff || out_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_tready = s1_ready;
   assign req_fire   = req_tvalid && s1_ready;
   assign gen_fire   = req_fire && (req_func == FUNC_GEN);
   assign seed_fire  = req_fire && (req_func == FUNC_SEED);

   // Format register.
   logic output_format_ff, output_format_in;

   assign output_format_in = csr_wr_en ? csr_wr_data : output_format_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         output_format_ff <= FMT_RAW;
      end else begin
         output_format_ff <= output_format_in;
      end
   end

   // Lane state and step logic.
   logic [WORD_W-1:0] mix_a_ff [LANES];
   logic [WORD_W-1:0] mix_a_in [LANES];
   logic [WORD_W-1:0] mix_b_ff [LANES];
   logic [WORD_W-1:0] mix_b_in [LANES];
   logic [WORD_W-1:0] mix_c_ff [LANES];
   logic [WORD_W-1:0] mix_c_in [LANES];
   logic [WORD_W-1:0] count_ff [LANES];
   logic [WORD_W-1:0] count_in [LANES];
   logic [WORD_W-1:0] lane_sum [LANES];
   logic              seed_hit [LANES];

   for (genvar gi = 0; gi < LANES; gi++) begin : g_lane
      // Only the lanes that a lane index can reach take seed beats.
      if (gi < SEED_SLOTS) begin : g_seed
         assign seed_hit[gi] = seed_fire && (req_lane == LANE_IDX_W'(gi));
      end else begin : g_noseed
         assign seed_hit[gi] = 1'b0;
      end

      assign lane_sum[gi] = mix_a_ff[gi] + mix_b_ff[gi] + count_ff[gi];

      // Advance on a generate beat, load one word on a matching seed beat.
      always_comb begin
         mix_a_in[gi] = mix_a_ff[gi];
         mix_b_in[gi] = mix_b_ff[gi];
         mix_c_in[gi] = mix_c_ff[gi];
         count_in[gi] = count_ff[gi];
         if (gen_fire) begin
            count_in[gi] = count_ff[gi] + WORD_W'(1);
            mix_a_in[gi] = mix_b_ff[gi] ^ (mix_b_ff[gi] >> SHIFT_A);
            mix_b_in[gi] = mix_c_ff[gi] + (mix_c_ff[gi] << SHIFT_B);
            mix_c_in[gi] = ((mix_c_ff[gi] << ROT_C) | (mix_c_ff[gi] >> (WORD_W - ROT_C)))
                           + lane_sum[gi];
         end else if (seed_hit[gi]) begin
            case (req_sel)
               WORD_A:   mix_a_in[gi] = req_tdata;
               WORD_B:   mix_b_in[gi] = req_tdata;
               WORD_C:   mix_c_in[gi] = req_tdata;
               default:  count_in[gi] = req_tdata;
            endcase
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            mix_a_ff[gi] <= '0;
            mix_b_ff[gi] <= '0;
            mix_c_ff[gi] <= '0;
            count_ff[gi] <= '0;
         end else begin
            mix_a_ff[gi] <= mix_a_in[gi];
            mix_b_ff[gi] <= mix_b_in[gi];
            mix_c_ff[gi] <= mix_c_in[gi];
            count_ff[gi] <= count_in[gi];
         end
      end
   end

   // Valid bits of the three stages.
   always_comb begin
      s1_valid_in  = s1_ready ? gen_fire : s1_valid_ff;
      s2_valid_in  = s2_ready ? s1_valid_ff : s2_valid_ff;
      rsp_valid_in = out_ready ? s2_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Per output field: raw sum, leading-one search, then normalise.
   logic [WORD_W-1:0] s1_raw_ff  [OUT_FIELDS];
   logic [WORD_W-1:0] s1_raw_in  [OUT_FIELDS];
   logic [WORD_W-1:0] s2_raw_ff  [OUT_FIELDS];
   logic [WORD_W-1:0] s2_raw_in  [OUT_FIELDS];
   logic [POS_W-1:0]  s2_pos_ff  [OUT_FIELDS];
   logic [POS_W-1:0]  s2_pos_in  [OUT_FIELDS];
   logic [WORD_W-1:0] rsp_lane_ff [OUT_FIELDS];
   logic [WORD_W-1:0] rsp_lane_in [OUT_FIELDS];

   for (genvar go = 0; go < OUT_FIELDS; go++) begin : g_out
      logic [WORD_W-1:0] lane_raw;
      logic [FRAC_W-1:0] mant;
      logic [POS_W-1:0]  shamt;
      logic [FRAC_W-1:0] frac;
      logic [EXP_W-1:0]  expo;
      logic [WORD_W-1:0] dbl;

      // Fields with no lane behind them read as zero.
      if (go < LANES) begin : g_live
         assign lane_raw = lane_sum[go];
      end else begin : g_dead
         assign lane_raw = '0;
      end

      assign s1_raw_in[go] = gen_fire ? lane_raw : s1_raw_ff[go];
      assign s2_raw_in[go] = s2_ready ? s1_raw_ff[go] : s2_raw_ff[go];
      assign s2_pos_in[go] = s2_ready ? lead_one(s1_raw_ff[go][WORD_W-1:DROP_W])
                                      : s2_pos_ff[go];

      // The leading one shifts out past the fraction field.
      assign mant  = s2_raw_ff[go][WORD_W-1:DROP_W];
      assign shamt = POS_W'(FRAC_W) - s2_pos_ff[go];
      assign frac  = mant << shamt;
      assign expo  = EXP_W'(EXP_BASE) + EXP_W'(s2_pos_ff[go]);
      assign dbl   = (mant == '0) ? '0 : {1'b0, expo, frac};

      always_comb begin
         rsp_lane_in[go] = rsp_lane_ff[go];
         if (out_ready) begin
            rsp_lane_in[go] = (output_format_ff == FMT_DOUBLE) ? dbl : s2_raw_ff[go];
         end
      end

      always_ff @(posedge clock) begin
         s1_raw_ff[go]   <= s1_raw_in[go];
         s2_raw_ff[go]   <= s2_raw_in[go];
         s2_pos_ff[go]   <= s2_pos_in[go];
         rsp_lane_ff[go] <= rsp_lane_in[go];
      end

      assign rsp_tdata[go*WORD_W +: WORD_W] = rsp_lane_ff[go];
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule
